/* rtl/eoif_pkg.sv */
package eoif_pkg;

  localparam int MAX_EDGES_DEF = 64;
  localparam int POS_BITS_DEF  = 16;
  localparam int IN_POS_BITS   = 16;
  localparam int INDEX_BITS    = 6;

  typedef struct packed {
    logic [IN_POS_BITS-1:0] tail_pos;
    logic [IN_POS_BITS-1:0] head_pos;
    logic                   group_end;
  } item_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] earlier_index;
    logic [INDEX_BITS-1:0] later_index;
    logic                  run_end;
  } result_t;

  // per-cycle command broadcast to every sorter cell
  typedef struct packed {
    logic ins;    // insert the key into the sorted row
    logic shift;  // pop cell 0, everything moves one cell down
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

/* rtl/eoif_cell.sv */
module eoif_cell #(
  parameter int KEEP_BITS = 16,
  parameter int IDX_BITS  = 6,
  parameter int ENT_BITS  = 2 * KEEP_BITS + IDX_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  eoif_pkg::cell_ctl_t   ctl,
  input  logic [ENT_BITS-1:0]   key,
  input  logic [ENT_BITS-1:0]   left_ent,
  input  logic                  left_valid,
  input  logic                  left_ahead,
  input  logic [ENT_BITS-1:0]   right_ent,
  input  logic                  right_valid,
  output logic [ENT_BITS-1:0]   ent,
  output logic                  valid,
  output logic                  ahead
);

  logic [KEEP_BITS-1:0] k_tail, k_head, c_tail, c_head;

  assign k_tail = key[ENT_BITS-1 -: KEEP_BITS];
  assign k_head = key[ENT_BITS-KEEP_BITS-1 -: KEEP_BITS];
  assign c_tail = ent[ENT_BITS-1 -: KEEP_BITS];
  assign c_head = ent[ENT_BITS-KEEP_BITS-1 -: KEEP_BITS];

  // the key always has the highest arrival index, so equal keys stay behind
  assign ahead = !valid || (k_tail < c_tail) || ((k_tail == c_tail) && (k_head < c_head));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end else if (ctl.ins && ahead) begin
      valid <= left_ahead ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ent <= right_ent;
    end else if (ctl.ins && ahead) begin
      ent <= left_ahead ? left_ent : key;
    end
  end

endmodule

/* rtl/eoif_scan.sv */
module eoif_scan #(
  parameter int MAX_EDGES = eoif_pkg::MAX_EDGES_DEF,
  parameter int KEEP_BITS = 16,
  parameter int IDX_BITS  = $clog2(MAX_EDGES),
  parameter int CNT_BITS  = $clog2(MAX_EDGES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  group_end,
  output logic                  item_ready,
  output eoif_pkg::cell_ctl_t   ctl,
  output logic [IDX_BITS-1:0]   key_idx,
  input  logic [KEEP_BITS-1:0]  head0,
  input  logic [IDX_BITS-1:0]   idx0,
  output logic                  result_valid,
  input  logic                  result_ready,
  output eoif_pkg::result_t     result
);

  eoif_pkg::state_t     state;
  logic [CNT_BITS-1:0]  count;
  logic [KEEP_BITS-1:0] prev_head;
  logic [IDX_BITS-1:0]  prev_idx;
  logic                 prev_ok;
  logic [IDX_BITS-1:0]  pend_e, pend_l;
  logic                 pend_ok;

  logic accept, room, out_free, cand, adv, finish, emit_mid;

  assign item_ready = (state == eoif_pkg::ST_LOAD);
  assign accept     = item_valid && item_ready;
  assign room       = (count < CNT_BITS'(MAX_EDGES));
  assign key_idx    = count[IDX_BITS-1:0];
  assign out_free   = !result_valid || result_ready;

  assign cand     = prev_ok && (head0 < prev_head);
  // a second inversion pushes the held one out, which needs a free output slot
  assign adv      = (state == eoif_pkg::ST_SCAN) && (count != '0) &&
                    (!(cand && pend_ok) || out_free);
  assign emit_mid = adv && cand && pend_ok;
  assign finish   = (state == eoif_pkg::ST_SCAN) && (count == '0) && out_free;

  assign ctl.ins   = accept && room;
  assign ctl.shift = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= eoif_pkg::ST_LOAD;
      count   <= '0;
      prev_ok <= 1'b0;
      pend_ok <= 1'b0;
    end else begin
      case (state)
        eoif_pkg::ST_LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + CNT_BITS'(1);
            end
            if (group_end) begin
              state <= eoif_pkg::ST_SCAN;
            end
          end
        end
        eoif_pkg::ST_SCAN: begin
          if (adv) begin
            count   <= count - CNT_BITS'(1);
            prev_ok <= 1'b1;
            if (cand) begin
              pend_ok <= 1'b1;
            end
          end
          if (finish) begin
            prev_ok <= 1'b0;
            pend_ok <= 1'b0;
            state   <= eoif_pkg::ST_LOAD;
          end
        end
        default: begin
          state <= eoif_pkg::ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prev_head <= head0;
      prev_idx  <= idx0;
      if (cand) begin
        pend_e <= prev_idx;
        pend_l <= idx0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_mid || finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_mid) begin
      result.found         <= 1'b1;
      result.earlier_index <= eoif_pkg::INDEX_BITS'(pend_e);
      result.later_index   <= eoif_pkg::INDEX_BITS'(pend_l);
      result.run_end       <= 1'b0;
    end else if (finish) begin
      result.found         <= pend_ok;
      result.earlier_index <= pend_ok ? eoif_pkg::INDEX_BITS'(pend_e) : '0;
      result.later_index   <= pend_ok ? eoif_pkg::INDEX_BITS'(pend_l) : '0;
      result.run_end       <= 1'b1;
    end
  end

  a_ins_shift_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.ins && ctl.shift))
    else $error("insert and pop in the same cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(MAX_EDGES))
    else $error("edge count beyond capacity");

  a_load_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == eoif_pkg::ST_LOAD) |-> (!pend_ok && !prev_ok))
    else $error("scan state left over while loading");

  a_group_closes: assert property (@(posedge clk) disable iff (rst)
    (state == eoif_pkg::ST_SCAN) ##1 (state == eoif_pkg::ST_LOAD)
      |-> (result_valid && result.run_end))
    else $error("group ended without a final result beat");

  a_mid_not_final: assert property (@(posedge clk) disable iff (rst)
    emit_mid |=> (result_valid && result.found && !result.run_end))
    else $error("intermediate inversion beat malformed");

endmodule

/* rtl/edge_order_inversion_finder_unit.sv */
// Edge order inversion finder.
// item channel (item_valid/item_ready/item): one edge per beat, tail and head
// positions plus group_end on the last edge of a label group. While a group
// loads, one edge is taken every cycle and inserted into a row of MAX_EDGES
// sorting cells kept in (tail, head, arrival) order. Edges past MAX_EDGES are
// dropped; a dropped group_end still closes the group.
// After the group_end beat the row is popped one cell per cycle from cell 0
// unless the result channel stalls it, each popped edge compared with the
// one before it. item_ready stays low until the scan of the group ends.
// result channel (result_valid/result_ready/result): one beat per inversion
// found, run_end on the last; a group with none gives a single beat with
// found low. An earlier beat goes valid the cycle after the pop that finds
// the next inversion; the final beat goes valid the cycle after the scan
// ends, if the output is free.
// A stalled result channel holds one beat in the output register; the scan
// stops only when a further beat must be written.
// rst (synchronous) empties the row, clears the count and drops any beat
// held in the output register.
module edge_order_inversion_finder_unit #(
  parameter int MAX_EDGES = eoif_pkg::MAX_EDGES_DEF,
  parameter int POS_BITS  = eoif_pkg::POS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  eoif_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_ready,
  output eoif_pkg::result_t  result
);

  localparam int KEEP_BITS = (POS_BITS < eoif_pkg::IN_POS_BITS) ? POS_BITS
                                                               : eoif_pkg::IN_POS_BITS;
  localparam int IDX_BITS  = $clog2(MAX_EDGES);
  localparam int CNT_BITS  = $clog2(MAX_EDGES + 1);
  localparam int ENT_BITS  = 2 * KEEP_BITS + IDX_BITS;

  eoif_pkg::cell_ctl_t  ctl;
  logic [IDX_BITS-1:0]  key_idx;
  logic [ENT_BITS-1:0]  key;

  logic [ENT_BITS-1:0]  ent   [MAX_EDGES];
  logic                 valid [MAX_EDGES];
  logic                 ahead [MAX_EDGES];

  assign key = {item.tail_pos[KEEP_BITS-1:0], item.head_pos[KEEP_BITS-1:0], key_idx};

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_row
    logic [ENT_BITS-1:0] l_ent, r_ent;
    logic                l_valid, l_ahead, r_valid;

    if (i == 0) begin : g_first
      assign l_ent   = '0;
      assign l_valid = 1'b0;
      assign l_ahead = 1'b0;
    end else begin : g_mid_l
      assign l_ent   = ent[i-1];
      assign l_valid = valid[i-1];
      assign l_ahead = ahead[i-1];
    end

    if (i == MAX_EDGES - 1) begin : g_last
      assign r_ent   = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_ent   = ent[i+1];
      assign r_valid = valid[i+1];
    end

    eoif_cell #(
      .KEEP_BITS (KEEP_BITS),
      .IDX_BITS  (IDX_BITS),
      .ENT_BITS  (ENT_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key         (key),
      .left_ent    (l_ent),
      .left_valid  (l_valid),
      .left_ahead  (l_ahead),
      .right_ent   (r_ent),
      .right_valid (r_valid),
      .ent         (ent[i]),
      .valid       (valid[i]),
      .ahead       (ahead[i])
    );
  end

  eoif_scan #(
    .MAX_EDGES (MAX_EDGES),
    .KEEP_BITS (KEEP_BITS),
    .IDX_BITS  (IDX_BITS),
    .CNT_BITS  (CNT_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .group_end    (item.group_end),
    .item_ready   (item_ready),
    .ctl          (ctl),
    .key_idx      (key_idx),
    .head0        (ent[0][ENT_BITS-KEEP_BITS-1 -: KEEP_BITS]),
    .idx0         (ent[0][IDX_BITS-1:0]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
